>>> rtl/core/pfs_pkg.sv
// Shared types and constants for the pulse frequency sweep block.
// Depends on nothing; every module of the block refers to it by scoped names.
package pfs_pkg;

    localparam int FREQ_W     = 11;
    localparam int PERIOD_W   = 3;
    localparam int SHIFT_W    = 3;
    localparam int TIMER_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // A zero period reloads the sweep timer with this count.
    localparam logic [TIMER_W-1:0] TIMER_ON_ZERO = TIMER_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PERIOD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DECREASE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_SHIFT    = CFG_IDX_W'(2);

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                decrease;
        logic [SHIFT_W-1:0]  shift;
    } t_cfg;

    typedef struct packed {
        logic              write;
        logic [FREQ_W-1:0] freq;
        logic              enabled;
    } t_result;

endpackage

>>> rtl/core/pfs_cfg.sv
// Configuration registers of the pulse frequency sweep block.
// Depends on pfs_pkg for the register indexes and the t_cfg struct.
module pfs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pfs_pkg::t_cfg                  o_cfg
);

    pfs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfs_pkg::CFG_SWEEP_PERIOD: begin
                    r_cfg.period <= i_cfg_data[pfs_pkg::PERIOD_W-1:0];
                end
                pfs_pkg::CFG_SWEEP_DECREASE: begin
                    r_cfg.decrease <= i_cfg_data[0];
                end
                pfs_pkg::CFG_SWEEP_SHIFT: begin
                    r_cfg.shift <= i_cfg_data[pfs_pkg::SHIFT_W-1:0];
                end
                default: begin
                    // Unknown index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/pfs_calc.sv
// One sweep step: frequency plus or minus itself shifted right, with overflow.
// Depends on pfs_pkg for widths and the t_cfg struct.
module pfs_calc (
    input  logic [pfs_pkg::FREQ_W-1:0] i_freq,
    input  pfs_pkg::t_cfg              i_cfg,
    output logic [pfs_pkg::FREQ_W-1:0] o_next,
    output logic                       o_overflow
);

    logic [pfs_pkg::FREQ_W-1:0] delta;
    logic [pfs_pkg::FREQ_W:0]   sum;

    always_comb begin
        delta = i_freq >> i_cfg.shift;
        if (i_cfg.decrease) begin
            // Subtracting a right-shifted copy can never go below zero.
            sum = {1'b0, i_freq - delta};
        end else begin
            sum = {1'b0, i_freq} + {1'b0, delta};
        end
        o_next     = sum[pfs_pkg::FREQ_W-1:0];
        o_overflow = sum[pfs_pkg::FREQ_W];
    end

endmodule

>>> rtl/core/pfs_state.sv
// Sweep state (shadow frequency, timer, enable) and the per-transaction update.
// Depends on pfs_pkg and instantiates pfs_calc twice.
module pfs_state (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_kind,
    input  logic [pfs_pkg::FREQ_W-1:0] i_channel_frequency,
    input  pfs_pkg::t_cfg              i_cfg,
    output pfs_pkg::t_result           o_result
);

    logic [pfs_pkg::FREQ_W-1:0]  r_shadow;
    logic [pfs_pkg::TIMER_W-1:0] r_timer;
    logic                        r_active;

    logic [pfs_pkg::FREQ_W-1:0]  n_shadow;
    logic [pfs_pkg::TIMER_W-1:0] n_timer;
    logic                        n_active;
    pfs_pkg::t_result            n_result;

    logic [pfs_pkg::FREQ_W-1:0]  first_in;
    logic [pfs_pkg::FREQ_W-1:0]  first_next;
    logic                        first_ovf;
    logic [pfs_pkg::FREQ_W-1:0]  second_next;
    logic                        second_ovf;
    logic [pfs_pkg::TIMER_W-1:0] reload;

    // The first unit checks a trigger's channel frequency or steps the shadow;
    // the second checks the step after a successful write.
    assign first_in = (i_kind == pfs_pkg::KIND_TRIGGER) ? i_channel_frequency : r_shadow;

    pfs_calc u_calc_first (
        .i_freq     (first_in),
        .i_cfg      (i_cfg),
        .o_next     (first_next),
        .o_overflow (first_ovf)
    );

    pfs_calc u_calc_second (
        .i_freq     (first_next),
        .i_cfg      (i_cfg),
        .o_next     (second_next),
        .o_overflow (second_ovf)
    );

    assign reload = (i_cfg.period != '0)
                  ? {{(pfs_pkg::TIMER_W-pfs_pkg::PERIOD_W){1'b0}}, i_cfg.period}
                  : pfs_pkg::TIMER_ON_ZERO;

    always_comb begin
        n_shadow = r_shadow;
        n_timer  = r_timer;
        n_active = r_active;
        n_result = '0;
        if (i_kind == pfs_pkg::KIND_TRIGGER) begin
            n_shadow = i_channel_frequency;
            n_timer  = reload;
            n_active = !((i_cfg.shift != '0) && first_ovf);
        end else if (r_timer > pfs_pkg::TIMER_W'(1)) begin
            n_timer = r_timer - pfs_pkg::TIMER_W'(1);
        end else begin
            n_timer = reload;
            if (r_active && (i_cfg.period != '0) && (i_cfg.shift != '0)) begin
                if (first_ovf) begin
                    n_active = 1'b0;
                end else begin
                    n_result.write = 1'b1;
                    n_result.freq  = first_next;
                    n_shadow       = first_next;
                    n_active       = !second_ovf;
                end
            end
        end
        n_result.enabled = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow <= '0;
            r_timer  <= '0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_shadow <= n_shadow;
            r_timer  <= n_timer;
            r_active <= n_active;
        end
    end

    assign o_result = n_result;

    // The reload count never exceeds the zero-period value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer <= pfs_pkg::TIMER_ON_ZERO)
        else $error("sweep timer above reload range");

    // A written frequency becomes the new shadow frequency.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_result.write) |=> (r_shadow == $past(n_result.freq)))
        else $error("shadow frequency not updated by write");

    // Only a trigger can turn a disabled sweep back on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_active && !(i_step && (i_kind == pfs_pkg::KIND_TRIGGER))) |=> !r_active)
        else $error("sweep re-enabled without trigger");

    // A write only comes from a tick with a nonzero period and shift.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_result.write |-> ((i_kind == pfs_pkg::KIND_TICK) && (i_cfg.period != '0)
                            && (i_cfg.shift != '0)))
        else $error("frequency write outside a sweep step");

    // A decreasing sweep never raises the frequency on the look-ahead step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cfg.decrease) |-> (second_next <= first_next))
        else $error("decreasing step raised the frequency");

endmodule

>>> rtl/core/pulse_frequency_sweep_top.sv
// Top level of the pulse frequency sweep block: input and result registers.
// Depends on pfs_pkg and instantiates pfs_cfg and pfs_state.
//
// Usage: each input transaction is either a sweep clock tick (kind 0) or a
// channel trigger (kind 1, with the channel frequency). Every transaction
// produces exactly one result transaction carrying a write strobe, the new
// frequency (zero when no write) and the sweep enable after that transaction.
// A transaction is taken on a rising edge where valid is high and stall is
// low, on either channel.
// The item is captured in an input register, then the sweep step (shift,
// add, overflow check, and a second check after a write) runs between that
// register and the result register. Throughput is one transaction per cycle
// while the receiver does not stall; a new item is accepted while a finished
// result still waits in the result register as long as the result register
// drains or the input register is empty.
// When the receiver stalls, the result holds and the pipeline fills; input
// stall rises once both registers are full.
// Configuration registers use the plain write port; the user must change them
// only while no transactions are in flight, which the block does not enforce.
// Synchronous active-low reset clears the pipeline valids, the configuration
// registers, the shadow frequency, the sweep timer and the sweep enable.
module pulse_frequency_sweep_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [pfs_pkg::FREQ_W-1:0]     i_channel_frequency,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_frequency_write,
    output logic [pfs_pkg::FREQ_W-1:0]     o_new_frequency,
    output logic                           o_sweep_enabled,
    input  logic                           i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                       r_in_valid;
    logic                       r_in_kind;
    logic [pfs_pkg::FREQ_W-1:0] r_in_freq;
    logic                       r_out_valid;
    pfs_pkg::t_result           r_out;

    pfs_pkg::t_cfg              cfg;
    pfs_pkg::t_result           step_result;
    logic                       advance;
    logic                       step;
    logic                       in_take;

    // The result register can load when it is empty or being drained.
    assign advance = !r_out_valid || !i_out_stall;
    assign step    = r_in_valid && advance;
    assign in_take = i_in_valid && !o_in_stall;

    // The input register frees up whenever its item moves to the result side.
    assign o_in_stall = r_in_valid && !advance;

    pfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pfs_state u_state (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (step),
        .i_kind              (r_in_kind),
        .i_channel_frequency (r_in_freq),
        .i_cfg               (cfg),
        .o_result            (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_kind <= i_kind;
            r_in_freq <= i_channel_frequency;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frequency_write = r_out.write;
    assign o_new_frequency   = r_out.freq;
    assign o_sweep_enabled   = r_out.enabled;

    // A held result must not be overwritten by the next step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !step)
        else $error("result register overwritten while stalled");

    // An accepted item is in the input register on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted transaction lost");

    // A step always yields a valid result on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("step produced no result");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for pulse_frequency_sweep_top: directed and random traffic.
// Depends on pfs_pkg and the RTL of the block; a small tracker class predicts every result.
module tb_top;

    import pfs_pkg::*;

    // Largest legal frequency, one bit wider so that an overflowing step can be seen.
    localparam logic [FREQ_W:0] FREQ_LIMIT = {1'b0, {FREQ_W{1'b1}}};

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);

    // Random transactions per idling phase, roughly a third of the whole run each.
    localparam int PHASE_ITEMS = 667;

    // Cycles left after the queue drains: the pipeline is two stages deep.
    localparam int DRAIN_PAD   = 4;
    localparam int TAIL_CYCLES = 10;

    // Cycles without any handshake or register write before the run is declared hung.
    localparam int HANG_LIMIT  = 5000;

    // Tracks the sweep state from the accepted transactions and keeps the results
    // that the block still owes, oldest first.
    class sweep_tracker;
        t_cfg               cfg;
        logic [FREQ_W-1:0]  shadow_freq;
        logic [TIMER_W-1:0] timer_cnt;
        logic               enabled;
        t_result            owed_results[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        writes_seen;
        int unsigned        disables_seen;

        function new();
            cfg           = '0;
            shadow_freq   = '0;
            timer_cnt     = '0;
            enabled       = 1'b0;
            mismatches    = 0;
            checked       = 0;
            writes_seen   = 0;
            disables_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SWEEP_PERIOD:   cfg.period   = data[PERIOD_W-1:0];
                CFG_SWEEP_DECREASE: cfg.decrease = data[0];
                CFG_SWEEP_SHIFT:    cfg.shift    = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        // Frequency that the next sweep step would produce; may exceed the limit.
        function logic [FREQ_W:0] stepped_freq();
            logic [FREQ_W:0] delta;
            delta = {1'b0, shadow_freq} >> cfg.shift;
            if (cfg.decrease) begin
                return {1'b0, shadow_freq} - delta;
            end
            return {1'b0, shadow_freq} + delta;
        endfunction

        function logic [TIMER_W-1:0] reload_count();
            return (cfg.period != '0) ? TIMER_W'(cfg.period) : TIMER_ON_ZERO;
        endfunction

        function void take_item(logic kind, logic [FREQ_W-1:0] freq);
            t_result         res;
            logic [FREQ_W:0] nxt;
            logic            was_enabled;
            res         = '0;
            was_enabled = enabled;
            if (kind == KIND_TRIGGER) begin
                shadow_freq = freq;
                timer_cnt   = reload_count();
                enabled     = 1'b1;
                if (cfg.shift != '0 && stepped_freq() > FREQ_LIMIT) begin
                    enabled = 1'b0;
                end
            end else if (timer_cnt > TIMER_W'(1)) begin
                timer_cnt = timer_cnt - 1'b1;
            end else begin
                timer_cnt = reload_count();
                if (enabled && cfg.period != '0 && cfg.shift != '0) begin
                    nxt = stepped_freq();
                    if (nxt > FREQ_LIMIT) begin
                        enabled = 1'b0;
                    end else begin
                        res.write   = 1'b1;
                        res.freq    = nxt[FREQ_W-1:0];
                        shadow_freq = nxt[FREQ_W-1:0];
                        writes_seen++;
                        if (stepped_freq() > FREQ_LIMIT) begin
                            enabled = 1'b0;
                        end
                    end
                end
            end
            if (was_enabled && !enabled) begin
                disables_seen++;
            end
            res.enabled = enabled;
            owed_results.push_back(res);
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: frequency_write=%0d new_frequency=%0d sweep_enabled=%0d",
                       got.write, got.freq, got.enabled);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.write !== want.write) begin
                $error("frequency_write: expected %0d, actual %0d", want.write, got.write);
                mismatches++;
            end
            if (got.freq !== want.freq) begin
                $error("new_frequency: expected %0d, actual %0d", want.freq, got.freq);
                mismatches++;
            end
            if (got.enabled !== want.enabled) begin
                $error("sweep_enabled: expected %0d, actual %0d", want.enabled, got.enabled);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_kind;
    logic [FREQ_W-1:0]     i_channel_frequency;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_frequency_write;
    logic [FREQ_W-1:0]     o_new_frequency;
    logic                  o_sweep_enabled;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sweep_tracker tracker;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned items_taken;
    int unsigned settings_used;
    int unsigned stuck_cycles;

    pulse_frequency_sweep_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_channel_frequency (i_channel_frequency),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frequency_write   (o_frequency_write),
        .o_new_frequency     (o_new_frequency),
        .o_sweep_enabled     (o_sweep_enabled),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver decides afresh every cycle whether to stall the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Everything is sampled at the rising edge, where the block samples it too, and all
    // stimulus changes through nonblocking assignments, so no result depends on the
    // order of processes within a time step. Results are checked before the input of
    // the same edge is noted; an input reaches the result only through both registers.
    always @(posedge i_clk) begin : monitor
        logic    progress;
        t_result seen;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen.write   = o_frequency_write;
                seen.freq    = o_new_frequency;
                seen.enabled = o_sweep_enabled;
                tracker.match_result(seen);
                progress = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.take_item(i_kind, i_channel_frequency);
                items_taken <= items_taken + 1;
                progress = 1'b1;
            end
            if (i_cfg_we) begin
                tracker.write_reg(i_cfg_index, i_cfg_data);
                progress = 1'b1;
            end
        end
        stuck_cycles <= progress ? 0 : stuck_cycles + 1;
    end

    // A hung handshake ends the run here instead of letting it spin forever.
    initial begin : watchdog
        @(posedge i_clk);
        while (stuck_cycles < HANG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offers one transaction and returns at the edge where it is accepted. This task only
    // lowers valid inside the idle loop, so back-to-back transactions keep it high and no step
    // sees it lowered and raised again. While idle, the payload carries junk on purpose.
    task automatic send_item(input logic kind, input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid          <= 1'b0;
            i_kind              <= 1'($urandom);
            i_channel_frequency <= FREQ_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_kind              <= kind;
        i_channel_frequency <= freq;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every owed result has come back, then gives the
    // pipeline the DRAIN_PAD wait so the block is idle for a register write.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all three sweep registers; the unmapped index gets junk first, which the
    // block must drop without touching any real register.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] decrease,
                              input logic [CFG_DATA_W-1:0] shift);
        put_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        put_reg(CFG_SWEEP_PERIOD, period);
        put_reg(CFG_SWEEP_DECREASE, decrease);
        put_reg(CFG_SWEEP_SHIFT, shift);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One random setting followed by a trigger and mostly ticks, so the sweep actually
    // steps. A few extra triggers restart it, and a few transactions have random kind.
    task automatic run_segment(input int n_items);
        logic [CFG_DATA_W-1:0] period;
        logic [CFG_DATA_W-1:0] shift;
        logic [CFG_DATA_W-1:0] decrease;
        logic [FREQ_W-1:0]     freq;
        int unsigned           roll;
        period   = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(7, 1));
        shift    = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(7, 1));
        decrease = CFG_DATA_W'($urandom);
        write_regs(period, decrease, shift);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (i == 0 || roll < 8) begin
                // Spread trigger frequencies over tiny, middle, near-maximum and any value.
                case ($urandom_range(3))
                    0:       freq = FREQ_W'($urandom);
                    1:       freq = FREQ_W'($urandom_range(63));
                    2:       freq = FREQ_W'($urandom_range(2047, 1536));
                    default: freq = FREQ_W'($urandom_range(1023, 256));
                endcase
                send_item(KIND_TRIGGER, freq);
            end else if (roll < 12) begin
                send_item(1'($urandom), FREQ_W'($urandom));
            end else begin
                send_item(KIND_TICK, FREQ_W'($urandom));
            end
        end
        settle();
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        tracker             = new();
        items_taken         = 0;
        settings_used       = 0;
        stuck_cycles        = 0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_kind              <= KIND_TICK;
        i_channel_frequency <= '0;
        i_out_stall         <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_SWEEP_PERIOD;
        i_cfg_data          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the timer left at zero by reset expires on the first tick and
        // reloads as eight, and with shift zero a trigger runs no overflow check.
        send_item(KIND_TICK, '1);
        send_item(KIND_TRIGGER, FREQ_W'(2047));
        send_item(KIND_TICK, '0);
        settle();

        // Fastest increasing sweep: a write, then the look-ahead check disables it.
        // A trigger at the maximum overflows at once, and a zero shadow writes zero.
        write_regs(CFG_DATA_W'(1), CFG_DATA_W'(0), CFG_DATA_W'(1));
        send_item(KIND_TRIGGER, FREQ_W'(1024));
        send_item(KIND_TICK, '0);
        send_item(KIND_TICK, '1);
        send_item(KIND_TRIGGER, FREQ_W'(2047));
        send_item(KIND_TICK, '0);
        send_item(KIND_TRIGGER, '0);
        send_item(KIND_TICK, '1);
        settle();

        // Slowest decreasing sweep with the largest shift: it can never overflow.
        write_regs(CFG_DATA_W'(7), CFG_DATA_W'(1), CFG_DATA_W'(7));
        send_item(KIND_TRIGGER, FREQ_W'(2047));
        repeat (7) send_item(KIND_TICK, FREQ_W'($urandom));
        settle();

        // Zero period with a nonzero shift: the timer reloads as eight and never steps.
        write_regs(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(3));
        send_item(KIND_TRIGGER, FREQ_W'(100));
        send_item(KIND_TICK, '0);
        settle();

        // Nonzero period with a zero shift: a trigger skips its check, ticks never step.
        write_regs(CFG_DATA_W'(2), CFG_DATA_W'(0), CFG_DATA_W'(0));
        send_item(KIND_TRIGGER, FREQ_W'(2047));
        send_item(KIND_TICK, '0);
        send_item(KIND_TICK, '0);
        settle();

        // Random part in three mixes: busy sender with a stalling receiver, the reverse,
        // and both sides at full rate.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 87;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 32;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_start = items_taken;
            while (items_taken - phase_start < PHASE_ITEMS) begin
                run_segment($urandom_range(60, 20));
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.owed_results.size() != 0) begin
            $error("%0d results never arrived", tracker.owed_results.size());
            tracker.mismatches++;
        end

        $display("Run covered %0d input transactions and %0d checked results over %0d register settings.",
                 items_taken, tracker.checked, settings_used);
        $display("Sweep wrote the frequency %0d times and was disabled by overflow %0d times.",
                 tracker.writes_seen, tracker.disables_seen);
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
